/* src/rrsa_pkg.sv */
// ----------------------------------------------------------------------------
// rrsa_pkg: shared types and constants for the round-robin slot allocator
// Word layouts, opcodes, register map and controller/datapath handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

package rrsa_pkg;

  localparam int unsigned SLOT_W  = 6;   // slot index field
  localparam int unsigned CNT_W   = 7;   // slot count register
  localparam int unsigned SHIFT_W = 5;   // page shift register
  localparam int unsigned GEN_W   = 32;  // generation counter
  localparam int unsigned SIZE_W  = 32;  // requested size
  localparam int unsigned RSIZE_W = 33;  // page-rounded size
  localparam int unsigned ADDR_W  = 3;
  localparam int unsigned DATA_W  = 32;

  localparam logic [CNT_W-1:0]   SLOT_COUNT_RST = 7'd16;
  localparam logic [SHIFT_W-1:0] PAGE_SHIFT_RST = 5'd12;  // 4096-byte pages
  localparam logic [GEN_W-1:0]   GEN_RST        = 32'd1;

  typedef enum logic [1:0] {
    OP_ACQUIRE = 2'd0,
    OP_RELEASE = 2'd1,
    OP_RETIRE  = 2'd2,
    OP_NOP     = 2'd3
  } op_e;

  // register select is byte address bit 2
  typedef enum logic {
    REG_SLOT_COUNT = 1'b0,
    REG_PAGE_SHIFT = 1'b1
  } reg_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EXEC = 2'd1,
    ST_NORM = 2'd2
  } state_e;

  typedef struct packed {
    op_e                opcode;
    logic [SLOT_W-1:0]  slot_index;
    logic [SIZE_W-1:0]  new_size;
  } in_word_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  granted_index;
    logic               grant_ok;
    logic [GEN_W-1:0]   generation;
    logic [RSIZE_W-1:0] current_size;
  } out_word_t;

  typedef struct packed {
    logic accept;      // latch word and search masks
    logic commit;      // apply update, load output word
    logic norm_start;  // begin head modulo pool size
    logic norm_step;   // one remainder bit
    logic norm_last;   // final remainder bit, load start
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;    // output register can take a word
    logic norm_req;    // pool size changed, start needs recompute
    logic cfg_busy;    // register write in progress
  } dp_stat_t;

endpackage

`default_nettype wire

/* src/rrsa_ctrl.sv */
// ----------------------------------------------------------------------------
// rrsa_ctrl: sequencer for the slot allocator
// Accepts one word at a time and steps the head normalization.
// ----------------------------------------------------------------------------
`default_nettype none

module rrsa_ctrl #(
  parameter int unsigned IW = 6
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire rrsa_pkg::dp_stat_t stat_i,
  output rrsa_pkg::ctrl_cmd_t     cmd_o
);

  localparam int unsigned CW = (IW > 1) ? $clog2(IW) : 1;

  rrsa_pkg::state_e state_q, state_d;
  logic [CW-1:0]    cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rrsa_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      rrsa_pkg::ST_IDLE: begin
        if (stat_i.norm_req) begin
          cmd_o.norm_start = 1'b1;
          cnt_d            = '0;
          state_d          = rrsa_pkg::ST_NORM;
        end else begin
          in_ready_o = !stat_i.cfg_busy;
          if (in_valid_i && !stat_i.cfg_busy) begin
            cmd_o.accept = 1'b1;
            state_d      = rrsa_pkg::ST_EXEC;
          end
        end
      end
      rrsa_pkg::ST_EXEC: begin
        if (stat_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = rrsa_pkg::ST_IDLE;
        end
      end
      rrsa_pkg::ST_NORM: begin
        cmd_o.norm_step = 1'b1;
        if (cnt_q == CW'(IW - 1)) begin
          cmd_o.norm_last = 1'b1;
          state_d         = rrsa_pkg::ST_IDLE;
        end else begin
          cnt_d = cnt_q + CW'(1);
        end
      end
      default: begin
        state_d = rrsa_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* src/rrsa_dp.sv */
// ----------------------------------------------------------------------------
// rrsa_dp: allocator datapath
// Busy map, head/start pointers, generation, size, config regs, output reg.
// ----------------------------------------------------------------------------
`default_nettype none

module rrsa_dp #(
  parameter int unsigned MAX_SLOTS = 64,
  parameter int unsigned IW        = 6
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire rrsa_pkg::ctrl_cmd_t           cmd_i,
  output rrsa_pkg::dp_stat_t                 stat_o,
  input  wire rrsa_pkg::in_word_t            in_word_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output rrsa_pkg::out_word_t                out_word_o,
  input  wire logic                          psel_i,
  input  wire logic                          penable_i,
  input  wire logic                          pwrite_i,
  input  wire logic [rrsa_pkg::ADDR_W-1:0]   paddr_i,
  input  wire logic [rrsa_pkg::DATA_W-1:0]   pwdata_i,
  output logic [rrsa_pkg::DATA_W-1:0]        prdata_o
);

  localparam int unsigned CNT_W   = rrsa_pkg::CNT_W;
  localparam int unsigned RSIZE_W = rrsa_pkg::RSIZE_W;
  localparam logic [CNT_W-1:0] MAX_N = CNT_W'(MAX_SLOTS);

  // config
  logic [CNT_W-1:0]             slot_count_q;
  logic [rrsa_pkg::SHIFT_W-1:0] page_shift_q;
  logic                         norm_req_q;
  logic                         cfg_wr;
  rrsa_pkg::reg_e               reg_sel;

  // allocator state
  logic [MAX_SLOTS-1:0]         busy_q;
  logic [IW-1:0]                head_q;
  logic [IW-1:0]                start_q;   // head modulo pool size
  logic [rrsa_pkg::GEN_W-1:0]   gen_q;
  logic [RSIZE_W-1:0]           size_q;

  // latched word and search masks
  rrsa_pkg::in_word_t           word_q;
  logic [MAX_SLOTS-1:0]         hi_q;      // free slots at or past start
  logic [MAX_SLOTS-1:0]         lo_q;      // all free slots in pool

  // head normalization
  logic [CNT_W-1:0]             rem_q;
  logic [IW-1:0]                sh_q;
  logic [CNT_W-1:0]             rem_t;
  logic [CNT_W-1:0]             rem_n;

  // output register
  logic                         out_valid_q;
  rrsa_pkg::out_word_t          out_q;

  logic [CNT_W-1:0]             n_eff;
  logic [MAX_SLOTS-1:0]         in_pool;
  logic [MAX_SLOTS-1:0]         ge_start;
  logic [MAX_SLOTS-1:0]         sel;
  logic                         found;
  logic [IW-1:0]                idx;
  logic [IW-1:0]                head_next;
  logic [RSIZE_W-1:0]           page_mask;
  logic [RSIZE_W-1:0]           rounded;
  logic                         rel_hit;
  rrsa_pkg::out_word_t          res;

  assign cfg_wr  = psel_i && penable_i && pwrite_i;
  assign reg_sel = rrsa_pkg::reg_e'(paddr_i[2]);
  assign n_eff   = (slot_count_q > MAX_N) ? MAX_N : slot_count_q;

  always_comb begin
    case (reg_sel)
      rrsa_pkg::REG_SLOT_COUNT: prdata_o = rrsa_pkg::DATA_W'(slot_count_q);
      rrsa_pkg::REG_PAGE_SHIFT: prdata_o = rrsa_pkg::DATA_W'(page_shift_q);
      default:                  prdata_o = '0;
    endcase
  end

  for (genvar i = 0; i < MAX_SLOTS; i++) begin : g_mask
    assign in_pool[i]  = CNT_W'(i) < n_eff;
    assign ge_start[i] = IW'(i) >= start_q;
  end

  // rotating pick: lowest free at or past start, else lowest free overall
  always_comb begin
    sel   = (|hi_q) ? hi_q : lo_q;
    found = |lo_q;
    idx   = '0;
    for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
      if (sel[i]) begin
        idx = IW'(i);
      end
    end
  end

  assign head_next = ((CNT_W'(idx) + CNT_W'(1)) == n_eff) ? '0 : idx + IW'(1);

  assign page_mask = (RSIZE_W'(1) << page_shift_q) - RSIZE_W'(1);
  assign rounded   = (RSIZE_W'(word_q.new_size) + page_mask) & ~page_mask;

  assign rel_hit = {1'b0, word_q.slot_index} < n_eff;

  // one restoring-remainder bit per step
  always_comb begin
    rem_t = {rem_q[CNT_W-2:0], sh_q[IW-1]};
    rem_n = (rem_t >= n_eff) ? rem_t - n_eff : rem_t;
  end

  always_comb begin
    res               = '0;
    res.generation    = gen_q;
    res.current_size  = size_q;
    case (word_q.opcode)
      rrsa_pkg::OP_ACQUIRE: begin
        res.grant_ok      = found;
        res.granted_index = found ? rrsa_pkg::SLOT_W'(idx) : '0;
      end
      rrsa_pkg::OP_RETIRE: begin
        res.generation   = gen_q + rrsa_pkg::GEN_W'(1);
        res.current_size = rounded;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_count_q <= rrsa_pkg::SLOT_COUNT_RST;
      page_shift_q <= rrsa_pkg::PAGE_SHIFT_RST;
      norm_req_q   <= 1'b0;
      busy_q       <= '0;
      head_q       <= '0;
      start_q      <= '0;
      gen_q        <= rrsa_pkg::GEN_RST;
      size_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (reg_sel)
          rrsa_pkg::REG_SLOT_COUNT: begin
            slot_count_q <= pwdata_i[CNT_W-1:0];
            norm_req_q   <= 1'b1;
          end
          rrsa_pkg::REG_PAGE_SHIFT: page_shift_q <= pwdata_i[rrsa_pkg::SHIFT_W-1:0];
          default: begin
          end
        endcase
      end else if (cmd_i.norm_start) begin
        norm_req_q <= 1'b0;
      end

      if (cmd_i.norm_last) begin
        start_q <= rem_n[IW-1:0];
      end

      if (cmd_i.commit) begin
        case (word_q.opcode)
          rrsa_pkg::OP_ACQUIRE: begin
            if (found) begin
              busy_q[idx] <= 1'b1;
              head_q      <= head_next;
              start_q     <= head_next;
            end
          end
          rrsa_pkg::OP_RELEASE: begin
            if (rel_hit) begin
              busy_q[word_q.slot_index[IW-1:0]] <= 1'b0;
            end
          end
          rrsa_pkg::OP_RETIRE: begin
            busy_q  <= '0;
            head_q  <= '0;
            start_q <= '0;
            gen_q   <= res.generation;
            size_q  <= rounded;
          end
          default: begin
          end
        endcase
      end

      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      word_q <= in_word_i;
      hi_q   <= ~busy_q & in_pool & ge_start;
      lo_q   <= ~busy_q & in_pool;
    end
    if (cmd_i.norm_start) begin
      rem_q <= '0;
      sh_q  <= head_q;
    end else if (cmd_i.norm_step) begin
      rem_q <= rem_n;
      sh_q  <= sh_q << 1;
    end
    if (cmd_i.commit) begin
      out_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_word_o      = out_q;
  assign stat_o.out_free = !out_valid_q || out_ready_i;
  assign stat_o.norm_req = norm_req_q;
  assign stat_o.cfg_busy = cfg_wr;

endmodule

`default_nettype wire

/* src/round_robin_slot_allocator_unit.sv */
// ----------------------------------------------------------------------------
// round_robin_slot_allocator_unit: round-robin buffer slot allocator
// Busy bitmap with rotating head; acquire, release and retire commands,
// generation counter and page-rounded buffer size.
// ----------------------------------------------------------------------------
//
//   port group | dir | handshake              | word
//   -----------+-----+------------------------+--------------------------------
//   in_*       | in  | in_valid_i/in_ready_o  | opcode, slot_index, new_size
//   out_*      | out | out_valid_o/out_ready_i| granted_index, grant_ok,
//              |     |                        | generation, current_size
//   APB        | in  | psel/penable/pready    | 0x0 slot_count, 0x4 page_shift
//
// Per word: the accept edge latches the search masks; the commit, which waits
//   for a free output register, goes through the 64-wide rotating priority
//   pick. One word in flight at a time. After a slot_count write the head is
//   reduced modulo the pool size by a bit-serial remainder: a load step, then
//   one bit per cycle, with in_ready_o low from the write's access cycle on.
// Reset: all slots free, head 0, generation 1, size 0, slot_count 16,
//   page_shift 12.
// Stalls: the result sits in an output register; the next word is taken
//   while it waits, and commit holds until the output register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module round_robin_slot_allocator_unit #(
  parameter int unsigned MAX_SLOTS = 64
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // input words
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire rrsa_pkg::in_word_t            in_word_i,
  // result words
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output rrsa_pkg::out_word_t                out_word_o,
  // config port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [rrsa_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [rrsa_pkg::DATA_W-1:0]   pwdata,
  output logic [rrsa_pkg::DATA_W-1:0]        prdata,
  output logic                               pready
);

  // slot index width inside the pool
  localparam int unsigned IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

  rrsa_pkg::ctrl_cmd_t cmd;
  rrsa_pkg::dp_stat_t  stat;

  assign pready = 1'b1;

  rrsa_ctrl #(
    .IW (IW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  rrsa_dp #(
    .MAX_SLOTS (MAX_SLOTS),
    .IW        (IW)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .prdata_o    (prdata)
  );

  // one word at a time: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("accepted a word while another was in flight");

  // commit never overwrites a result still waiting
  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> stat.out_free)
    else $error("commit while output register held");

  // a failed or non-acquire result carries index zero
  a_no_grant_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.grant_ok |-> out_word_o.granted_index == '0)
    else $error("nonzero index without grant");

  // a commit always produces a result on the next cycle
  a_commit_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |=> out_valid_o)
    else $error("commit did not load output");

endmodule

`default_nettype wire

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// tb: self-checking bench for round_robin_slot_allocator_unit
// Drives acquire/release/retire words through a valid/ready driver, predicts
// each result word from a local copy of the busy bitmap, head, generation and
// stored size, and checks every result word in order. The pool size and page
// shift are rewritten over APB between drained phases.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned POOL_MAX   = 64;
  localparam int unsigned NUM_PHASES = 10;
  localparam int unsigned PHASE_WORDS = 138;

  localparam int unsigned SLOT_W  = rrsa_pkg::SLOT_W;
  localparam int unsigned CNT_W   = rrsa_pkg::CNT_W;
  localparam int unsigned SHIFT_W = rrsa_pkg::SHIFT_W;
  localparam int unsigned GEN_W   = rrsa_pkg::GEN_W;
  localparam int unsigned SIZE_W  = rrsa_pkg::SIZE_W;
  localparam int unsigned RSIZE_W = rrsa_pkg::RSIZE_W;
  localparam int unsigned ADDR_W  = rrsa_pkg::ADDR_W;
  localparam int unsigned DATA_W  = rrsa_pkg::DATA_W;

  // ---- clock, reset, DUT ports (all known from time zero) ----
  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  rrsa_pkg::in_word_t  in_word_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b1;
  rrsa_pkg::out_word_t out_word_o;
  logic                psel        = 1'b0;
  logic                penable     = 1'b0;
  logic                pwrite      = 1'b0;
  logic [ADDR_W-1:0]   paddr       = '0;
  logic [DATA_W-1:0]   pwdata      = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  // ---- allocator shadow state, mirrors the block ----
  logic [POOL_MAX-1:0] busy_bits      = '0;
  logic [SLOT_W-1:0]   head_ptr       = '0;
  logic [GEN_W-1:0]    gen_count      = rrsa_pkg::GEN_RST;
  logic [RSIZE_W-1:0]  stored_size    = '0;
  logic [CNT_W-1:0]    cfg_slot_count = rrsa_pkg::SLOT_COUNT_RST;
  logic [SHIFT_W-1:0]  cfg_page_shift = rrsa_pkg::PAGE_SHIFT_RST;

  // ---- bench bookkeeping ----
  rrsa_pkg::in_word_t  pending_words[$];     // words waiting for the driver
  rrsa_pkg::out_word_t expected_results[$];  // predicted result words, oldest first
  int unsigned fail_count = 0;
  int unsigned send_gap   = 0;
  int unsigned recv_gap   = 0;
  bit          quiet_tail = 1'b0;  // no idling in the last phase

  // Pool settings per random phase; covers empty pool, one slot, full and
  // oversized slot_count, and both page shift extremes.
  int unsigned count_plan [NUM_PHASES] = '{64, 1, 127, 5, 33, 0, 2, 64, 7, 16};
  int unsigned shift_plan [NUM_PHASES] = '{31, 0, 20, 3, 12, 7, 1, 31, 0, 12};

  round_robin_slot_allocator_unit #(
    .MAX_SLOTS (POOL_MAX)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Effective pool size: slot_count saturated at the bitmap depth.
  function automatic int unsigned pool_slots();
    return (cfg_slot_count > POOL_MAX) ? POOL_MAX : int'(cfg_slot_count);
  endfunction

  // Apply one accepted word to the shadow state, return its result word.
  function automatic rrsa_pkg::out_word_t alloc_predict(rrsa_pkg::in_word_t w);
    rrsa_pkg::out_word_t r;
    int unsigned         n;
    int unsigned         idx;
    bit                  found;
    logic [RSIZE_W-1:0]  page;
    logic [RSIZE_W-1:0]  sum;
    r     = '0;
    n     = pool_slots();
    found = 1'b0;
    case (w.opcode)
      rrsa_pkg::OP_ACQUIRE: begin
        // rotating search from head mod n; stale head is fine here
        for (int unsigned k = 0; k < n; k++) begin
          idx = (int'(head_ptr) + k) % n;
          if (!found && !busy_bits[idx]) begin
            found           = 1'b1;
            busy_bits[idx]  = 1'b1;
            head_ptr        = SLOT_W'((idx + 1) % n);
            r.granted_index = SLOT_W'(idx);
            r.grant_ok      = 1'b1;
          end
        end
      end
      rrsa_pkg::OP_RELEASE: begin
        if (w.slot_index < n) busy_bits[w.slot_index] = 1'b0;
      end
      rrsa_pkg::OP_RETIRE: begin
        busy_bits = '0;
        head_ptr  = '0;
        gen_count = gen_count + 1'b1;
        page      = RSIZE_W'(1) << cfg_page_shift;
        sum       = {1'b0, w.new_size} + page - 1'b1;
        stored_size = sum & ~(page - 1'b1);
      end
      default: ;  // unused opcode leaves state alone
    endcase
    r.generation   = gen_count;
    r.current_size = stored_size;
    return r;
  endfunction

  // ---- driver: one NBA per signal per edge ----
  always @(posedge clk_i) begin : drive
    logic               nv;
    rrsa_pkg::in_word_t nw;
    if (rst_ni) begin
      nv = in_valid_i;
      nw = in_word_i;
      if (in_valid_i && in_ready_o) begin
        expected_results.insert(expected_results.size(), alloc_predict(in_word_i));
        nv = 1'b0;
      end
      if (!nv) begin
        if (send_gap > 0) begin
          send_gap = send_gap - 1;
        end else if (pending_words.size() > 0) begin
          nw = pending_words.pop_front();
          nv = 1'b1;
          // gap starts once this word is taken
          if (!quiet_tail && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 12);
        end
      end
      in_valid_i <= nv;
      in_word_i  <= nw;
    end
  end

  // ---- monitor: check result words, throttle out_ready_i ----
  always @(posedge clk_i) begin : watch
    rrsa_pkg::out_word_t exp_w;
    logic                nr;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          fail_count = fail_count + 1;
          if (fail_count <= 10)
            $display("unexpected result word: idx=%0d ok=%0b gen=%0h size=%0h",
                     out_word_o.granted_index, out_word_o.grant_ok,
                     out_word_o.generation, out_word_o.current_size);
        end else begin
          exp_w = expected_results.pop_front();
          if (out_word_o.granted_index !== exp_w.granted_index ||
              out_word_o.grant_ok      !== exp_w.grant_ok      ||
              out_word_o.generation    !== exp_w.generation    ||
              out_word_o.current_size  !== exp_w.current_size) begin
            fail_count = fail_count + 1;
            if (fail_count <= 10)
              $display({"mismatch: exp idx=%0d ok=%0b gen=%0h size=%0h",
                        " | got idx=%0d ok=%0b gen=%0h size=%0h"},
                       exp_w.granted_index, exp_w.grant_ok, exp_w.generation,
                       exp_w.current_size, out_word_o.granted_index,
                       out_word_o.grant_ok, out_word_o.generation,
                       out_word_o.current_size);
          end
        end
      end
      nr = 1'b1;
      if (recv_gap > 0) begin
        recv_gap = recv_gap - 1;
        nr       = 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
        recv_gap = $urandom_range(1, 12) - 1;
        nr       = 1'b0;
      end
      out_ready_i <= nr;
    end
  end

  // ---- stimulus helpers ----
  task automatic queue_word(input rrsa_pkg::op_e op, input int unsigned slot,
                            input logic [SIZE_W-1:0] size);
    rrsa_pkg::in_word_t w;
    w.opcode     = op;
    w.slot_index = SLOT_W'(slot);
    w.new_size   = size;
    pending_words.insert(pending_words.size(), w);
  endtask

  // Sender holds off until every expected word is back and the block is quiet.
  task automatic wait_drained();
    while (pending_words.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // APB write: setup cycle, access cycle; pready is tied high.
  task automatic write_reg(input rrsa_pkg::reg_e sel, input logic [DATA_W-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (sel == rrsa_pkg::REG_SLOT_COUNT) cfg_slot_count = value[CNT_W-1:0];
    else                                 cfg_page_shift = value[SHIFT_W-1:0];
  endtask

  function automatic logic [SIZE_W-1:0] pick_size();
    case ($urandom_range(0, 3))
      0:       return $urandom;
      1:       return $urandom_range(0, 16384);
      2:       return 32'hFFFF_FFFF - $urandom_range(0, 15);
      default: return '0;
    endcase
  endfunction

  // Mostly acquire/release traffic on live slots, occasional fill-to-exhaustion
  // runs, some retires and a little noise (out-of-pool releases, unused opcode).
  task automatic queue_random(input int unsigned count);
    int unsigned made;
    int unsigned n;
    int unsigned r;
    made = 0;
    n    = pool_slots();
    while (made < count) begin
      if ($urandom_range(0, 19) == 0) begin
        for (int unsigned j = 0; j < n + 2; j++)
          queue_word(rrsa_pkg::OP_ACQUIRE, $urandom_range(0, 63), pick_size());
        made = made + n + 2;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55)
          queue_word(rrsa_pkg::OP_ACQUIRE, $urandom_range(0, 63), pick_size());
        else if (r < 90)
          queue_word(rrsa_pkg::OP_RELEASE,
                     ($urandom_range(0, 9) < 7) ? $urandom_range(0, (n > 0) ? n - 1 : 0)
                                                : $urandom_range(0, 63),
                     pick_size());
        else if (r < 95)
          queue_word(rrsa_pkg::OP_RETIRE, $urandom_range(0, 63), pick_size());
        else
          queue_word(rrsa_pkg::OP_NOP, $urandom_range(0, 63), pick_size());
        made = made + 1;
      end
    end
  endtask

  // ---- main sequence ----
  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, reset settings: 16 slots, 4 KiB pages
    queue_word(rrsa_pkg::OP_ACQUIRE, 0, 32'h0);
    queue_word(rrsa_pkg::OP_ACQUIRE, 63, 32'hFFFF_FFFF);
    queue_word(rrsa_pkg::OP_RELEASE, 0, 32'h0);
    queue_word(rrsa_pkg::OP_ACQUIRE, 0, 32'h0);            // head moved past slot 1
    queue_word(rrsa_pkg::OP_RELEASE, 63, 32'h0);           // beyond the pool, ignored
    queue_word(rrsa_pkg::OP_RELEASE, 15, 32'h0);
    queue_word(rrsa_pkg::OP_NOP, 63, 32'hFFFF_FFFF);
    queue_word(rrsa_pkg::OP_RETIRE, 0, 32'h0);             // zero size stays zero
    queue_word(rrsa_pkg::OP_RETIRE, 0, 32'hFFFF_FFFF);     // rounds up to 2^32
    queue_word(rrsa_pkg::OP_RETIRE, 0, 32'h1);
    queue_word(rrsa_pkg::OP_ACQUIRE, 0, 32'h0);
    wait_drained();

    // three-slot pool, largest page: exhaustion and wrap
    write_reg(rrsa_pkg::REG_SLOT_COUNT, 32'd3);
    write_reg(rrsa_pkg::REG_PAGE_SHIFT, 32'd31);
    for (int i = 0; i < 4; i++) queue_word(rrsa_pkg::OP_ACQUIRE, 0, 32'h0);
    queue_word(rrsa_pkg::OP_RELEASE, 1, 32'h0);
    queue_word(rrsa_pkg::OP_ACQUIRE, 0, 32'h0);
    queue_word(rrsa_pkg::OP_RETIRE, 0, 32'hFFFF_FFFF);
    queue_word(rrsa_pkg::OP_RETIRE, 0, 32'h8000_0000);
    wait_drained();

    // byte pages, then an empty pool
    write_reg(rrsa_pkg::REG_PAGE_SHIFT, 32'd0);
    queue_word(rrsa_pkg::OP_RETIRE, 0, 32'h1234_5677);
    wait_drained();
    write_reg(rrsa_pkg::REG_SLOT_COUNT, 32'd0);
    queue_word(rrsa_pkg::OP_ACQUIRE, 0, 32'h0);
    queue_word(rrsa_pkg::OP_RELEASE, 0, 32'h0);

    // random phases; head and high busy bits carry across pool changes
    for (int unsigned p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      if (p == NUM_PHASES - 1) quiet_tail = 1'b1;
      write_reg(rrsa_pkg::REG_SLOT_COUNT, count_plan[p]);
      write_reg(rrsa_pkg::REG_PAGE_SHIFT, shift_plan[p]);
      queue_random(PHASE_WORDS);
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (expected_results.size() != 0) fail_count = fail_count + 1;
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // watchdog
  initial begin
    #1000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

/* round_robin_slot_allocator_unit.f */
src/rrsa_pkg.sv
src/rrsa_ctrl.sv
src/rrsa_dp.sv
src/round_robin_slot_allocator_unit.sv
bench/tb.sv
